/* rtl/dfr_pkg.sv */
// Shared types and codes for the length-framed packet deframer.
// No dependencies; used by dfr_core and length_framed_packet_deframer_top.
package dfr_pkg;

  // Input transaction opcodes
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RD_ERR  = 2'd2;
  localparam logic [1:0] OP_GO_IDLE = 2'd3;

  // Result event codes
  localparam logic [2:0] EV_PAYLOAD = 3'd0;
  localparam logic [2:0] EV_GOOD    = 3'd1;
  localparam logic [2:0] EV_BAD     = 3'd2;
  localparam logic [2:0] EV_TIMEOUT = 3'd3;
  localparam logic [2:0] EV_IO_ERR  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_ENABLE  = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  // Framing bytes
  localparam logic [7:0] HDR1_BYTE   = 8'h80;
  localparam logic [7:0] HDR2_BYTE   = 8'h81;
  localparam logic [7:0] FOOTER_BYTE = 8'h82;

  // One result from the core to the output register
  typedef struct packed {
    logic        valid;
    logic [2:0]  event_res;
    logic [7:0]  data;
    logic        payload_last;
    logic [15:0] payload_length;
    logic        in_error;
  } dfr_res_t;

endpackage

/* rtl/dfr_core.sv */
// Deframer state machine: frame state registers and the next-state/result logic.
// Depends on dfr_pkg.
module dfr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [1:0]        opcode,
  input  logic [7:0]        rx_byte,
  input  logic              enable,
  input  logic [15:0]       timeout_ticks,
  output dfr_pkg::dfr_res_t res
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HUNT = 3'd1;
  localparam logic [2:0] PH_HDR2 = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_ERR  = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] frame_len_r, frame_len_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [2:0]  eff_phase;
  logic [15:0] ticks_inc;
  logic [16:0] seen_p1;
  logic [16:0] seen_p2;

  always_comb begin
    eff_phase = (phase_r == PH_IDLE && enable) ? PH_HUNT : phase_r;
    ticks_inc = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;
    seen_p1   = {1'b0, seen_r} + 17'd1;
    seen_p2   = {1'b0, seen_r} + 17'd2;

    phase_nxt     = phase_r;
    frame_len_nxt = frame_len_r;
    seen_nxt      = seen_r;
    ticks_nxt     = ticks_r;
    res           = '0;

    priority if (opcode == dfr_pkg::OP_GO_IDLE) begin
      phase_nxt = PH_IDLE;
    end else if (phase_r == PH_IDLE && !enable) begin
      phase_nxt = PH_IDLE;
    end else if (eff_phase >= PH_ERR) begin
      phase_nxt = PH_ERR;
    end else if (opcode == dfr_pkg::OP_RD_ERR) begin
      phase_nxt     = PH_ERR;
      res.valid     = 1'b1;
      res.event_res = dfr_pkg::EV_IO_ERR;
      res.in_error  = 1'b1;
    end else if (opcode == dfr_pkg::OP_TICK) begin
      phase_nxt = eff_phase;
      if (eff_phase != PH_HUNT) begin
        ticks_nxt = ticks_inc;
        if (ticks_inc >= timeout_ticks) begin
          phase_nxt     = PH_HUNT;
          res.valid     = 1'b1;
          res.event_res = dfr_pkg::EV_TIMEOUT;
        end
      end
    end else begin
      phase_nxt = eff_phase;
      unique case (eff_phase)
        PH_HUNT: begin
          if (rx_byte == dfr_pkg::HDR1_BYTE) begin
            phase_nxt = PH_HDR2;
            ticks_nxt = '0;
          end
        end
        PH_HDR2: begin
          ticks_nxt = '0;
          if (rx_byte == dfr_pkg::HDR2_BYTE) begin
            phase_nxt = PH_LEN;
            seen_nxt  = '0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_LEN: begin
          ticks_nxt = '0;
          if (seen_r == '0) begin
            frame_len_nxt = {8'd0, rx_byte};
            seen_nxt      = 16'd1;
          end else begin
            frame_len_nxt = {rx_byte, frame_len_r[7:0]};
            seen_nxt      = '0;
            if ({rx_byte, frame_len_r[7:0]} == '0) begin
              // zero length: reject at once
              phase_nxt     = PH_HUNT;
              res.valid     = 1'b1;
              res.event_res = dfr_pkg::EV_BAD;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          ticks_nxt = '0;
          if (seen_p1 < {1'b0, frame_len_r}) begin
            seen_nxt         = seen_p1[15:0];
            res.valid        = 1'b1;
            res.event_res    = dfr_pkg::EV_PAYLOAD;
            res.data         = rx_byte;
            res.payload_last = (seen_p2 == {1'b0, frame_len_r});
          end else begin
            phase_nxt          = PH_HUNT;
            res.valid          = 1'b1;
            res.event_res      = (rx_byte == dfr_pkg::FOOTER_BYTE) ?
                                 dfr_pkg::EV_GOOD : dfr_pkg::EV_BAD;
            res.payload_length = frame_len_r - 16'd1;
          end
        end
        default: begin
          phase_nxt = eff_phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      frame_len_r <= '0;
      seen_r      <= '0;
      ticks_r     <= '0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      frame_len_r <= frame_len_nxt;
      seen_r      <= seen_nxt;
      ticks_r     <= ticks_nxt;
    end
  end

endmodule

/* rtl/length_framed_packet_deframer_top.sv */
// Top level of the length-framed packet deframer: input register, config
// registers, result register. Depends on dfr_pkg and dfr_core.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_opcode, in_rx_byte
//   out_    | output    | out_valid/out_stall | out_event_res, out_data,
//           |           |                     | out_payload_last, out_payload_length,
//           |           |                     | out_in_error
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One transaction per cycle sustained unless out_stall holds a result; each result
// goes through the input register, then the result register, to out_.
// The frame state machine in dfr_core settles one transaction per fired cycle.
// rst_n is synchronous, active low; it clears state, valids and config to defaults.
// A stalled result holds in the output register; the input register keeps
// taking transactions that produce no result even while out_stall is high.
module length_framed_packet_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_data,
  output logic        out_payload_last,
  output logic [15:0] out_payload_length,
  output logic        out_in_error,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic              enable_r;
  logic [15:0]       timeout_r;

  logic              s1_valid_r, s1_valid_nxt;
  logic [1:0]        s1_opcode_r;
  logic [7:0]        s1_byte_r;

  logic              out_valid_r;
  dfr_pkg::dfr_res_t out_r;

  dfr_pkg::dfr_res_t res;
  logic              out_free;
  logic              s1_fire;
  logic              in_take;

  // User writes config only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      timeout_r <= dfr_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfr_pkg::CFG_ENABLE:  enable_r  <= cfg_wdata[0];
        dfr_pkg::CFG_TIMEOUT: timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame state machine works on the transaction held in the input register
  dfr_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (s1_fire),
    .opcode        (s1_opcode_r),
    .rx_byte       (s1_byte_r),
    .enable        (enable_r),
    .timeout_ticks (timeout_r),
    .res           (res)
  );

  // Advance the held transaction when its result (if any) has a place to go
  assign out_free     = !out_valid_r || !out_stall;
  assign s1_fire      = s1_valid_r && (out_free || !res.valid);
  assign in_stall     = s1_valid_r && !s1_fire;
  assign in_take      = in_valid && !in_stall;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_opcode_r <= in_opcode;
      s1_byte_r   <= in_rx_byte;
    end
  end

  // Result register: load on a firing transaction with a result, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_r.event_res;
  assign out_data           = out_r.data;
  assign out_payload_last   = out_r.payload_last;
  assign out_payload_length = out_r.payload_length;
  assign out_in_error       = out_r.in_error;

`ifndef SYNTHESIS
  a_err_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.in_error == (out_r.event_res == dfr_pkg::EV_IO_ERR)))
    else $error("in_error flag disagrees with event code");

  a_data_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.event_res != dfr_pkg::EV_PAYLOAD) |->
      (out_r.data == '0 && !out_r.payload_last))
    else $error("data or last set on a non-payload result");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |=>
      (s1_valid_r && $stable(s1_opcode_r) && $stable(s1_byte_r)))
    else $error("held input transaction lost or changed");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && res.valid) |=> out_valid_r)
    else $error("result of a fired transaction not registered");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(s1_fire && res.valid))
    else $error("stalled result overwritten");
`endif

endmodule

/* bench/length_framed_packet_deframer_top_test.sv */
// Self-checking bench for length_framed_packet_deframer_top: queue-fed driver,
// stalling receiver, built-in frame predictor and result checker.
// Depends on dfr_pkg and the deframer RTL.
module length_framed_packet_deframer_top_test;

  // Two register stages inside the block; give it some slack before config writes.
  localparam int RESULT_LATENCY = 2;
  localparam int SETTLE_CYCLES  = 4 * RESULT_LATENCY;
  // Longest legal quiet spell is a sender gap or a receiver stall run.
  localparam int STUCK_LIMIT    = 2000;

  // Predictor frame states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HUNT = 3'd1;
  localparam logic [2:0] ST_HDR2 = 3'd2;
  localparam logic [2:0] ST_LEN  = 3'd3;
  localparam logic [2:0] ST_DATA = 3'd4;
  localparam logic [2:0] ST_ERR  = 3'd5;

  typedef struct {
    logic [1:0] op;
    logic [7:0] rx;
  } link_item_t;

  typedef struct {
    logic [2:0]  event_res;
    logic [7:0]  data;
    logic        payload_last;
    logic [15:0] payload_length;
    logic        in_error;
  } frame_event_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode  = dfr_pkg::OP_BYTE;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_data;
  logic        out_payload_last;
  logic [15:0] out_payload_length;
  logic        out_in_error;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = dfr_pkg::CFG_ENABLE;
  logic [15:0] cfg_wdata  = 16'h0000;

  length_framed_packet_deframer_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_data           (out_data),
    .out_payload_last   (out_payload_last),
    .out_payload_length (out_payload_length),
    .out_in_error       (out_in_error),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Stimulus waiting for the driver, and events the block still owes us.
  link_item_t   link_items[$];
  frame_event_t expected_events[$];
  int unsigned  queued_count   = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  stuck_cycles   = 0;
  logic [15:0]  cur_timeout    = dfr_pkg::TIMEOUT_RESET;

  // Predictor state and its copy of the registers, reset values included.
  logic [2:0]   fr_state     = ST_IDLE;
  logic [15:0]  fr_len       = 16'h0000;
  logic [15:0]  fr_count     = 16'h0000;
  logic [15:0]  quiet_ticks  = 16'h0000;
  logic         pred_enable  = 1'b0;
  logic [15:0]  pred_timeout = dfr_pkg::TIMEOUT_RESET;

  // Advance the frame predictor by one accepted transaction and queue
  // the event it should cause, if any.
  task automatic predict_frame_event(input logic [1:0] op, input logic [7:0] b);
    frame_event_t ev;
    bit           fires;
    ev    = '{dfr_pkg::EV_PAYLOAD, 8'h00, 1'b0, 16'h0000, 1'b0};
    fires = 1'b0;
    if (op == dfr_pkg::OP_GO_IDLE) begin
      fr_state = ST_IDLE;
    end else if (fr_state == ST_IDLE && !pred_enable) begin
      // disabled and idle: drop everything
    end else begin
      // an enabled idle block treats this transaction as if already hunting
      if (fr_state == ST_IDLE) fr_state = ST_HUNT;
      if (fr_state == ST_ERR) begin
        // sticky error: only go-idle gets out
      end else if (op == dfr_pkg::OP_RD_ERR) begin
        fr_state    = ST_ERR;
        ev.event_res = dfr_pkg::EV_IO_ERR;
        ev.in_error  = 1'b1;
        fires        = 1'b1;
      end else if (op == dfr_pkg::OP_TICK) begin
        // no timeout outside a frame
        if (fr_state != ST_HUNT) begin
          if (quiet_ticks != 16'hFFFF) quiet_ticks = quiet_ticks + 16'd1;
          if (quiet_ticks >= pred_timeout) begin
            fr_state     = ST_HUNT;
            ev.event_res = dfr_pkg::EV_TIMEOUT;
            fires        = 1'b1;
          end
        end
      end else begin
        case (fr_state)
          ST_HUNT: begin
            if (b == dfr_pkg::HDR1_BYTE) begin
              fr_state    = ST_HDR2;
              quiet_ticks = 16'h0000;
            end
          end
          ST_HDR2: begin
            quiet_ticks = 16'h0000;
            if (b == dfr_pkg::HDR2_BYTE) begin
              fr_state = ST_LEN;
              fr_count = 16'h0000;
            end else begin
              fr_state = ST_HUNT;
            end
          end
          ST_LEN: begin
            quiet_ticks = 16'h0000;
            if (fr_count == 16'h0000) begin
              fr_len   = {8'h00, b};
              fr_count = 16'h0001;
            end else begin
              fr_len   = {b, fr_len[7:0]};
              fr_count = 16'h0000;
              // a zero length cannot even hold the footer: reject it now
              if (fr_len == 16'h0000) begin
                fr_state     = ST_HUNT;
                ev.event_res = dfr_pkg::EV_BAD;
                fires        = 1'b1;
              end else begin
                fr_state = ST_DATA;
              end
            end
          end
          default: begin
            quiet_ticks = 16'h0000;
            if (17'(fr_count) + 17'd1 < 17'(fr_len)) begin
              ev.event_res    = dfr_pkg::EV_PAYLOAD;
              ev.data         = b;
              ev.payload_last = (17'(fr_count) + 17'd2 == 17'(fr_len));
              fr_count        = fr_count + 16'd1;
            end else begin
              // last byte of the frame must be the footer
              fr_state          = ST_HUNT;
              ev.event_res      = (b == dfr_pkg::FOOTER_BYTE) ? dfr_pkg::EV_GOOD
                                                              : dfr_pkg::EV_BAD;
              ev.payload_length = fr_len - 16'd1;
            end
            fires = 1'b1;
          end
        endcase
      end
    end
    if (fires) expected_events.push_back(ev);
  endtask

  // Mirror config writes, predict on each accepted input transaction and
  // check each accepted result against the oldest expectation.
  logic in_taken = 1'b0;
  always @(posedge clk) begin
    frame_event_t exp_ev;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          dfr_pkg::CFG_ENABLE:  pred_enable  = cfg_wdata[0];
          dfr_pkg::CFG_TIMEOUT: pred_timeout = cfg_wdata;
        endcase
      end
      if (in_valid && !in_stall) predict_frame_event(in_opcode, in_rx_byte);
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("unexpected result: event_res %0d data %0h length %0d",
                 out_event_res, out_data, out_payload_length);
          mismatch_count++;
        end else begin
          exp_ev = expected_events.pop_front();
          if (out_event_res !== exp_ev.event_res) begin
            $error("event_res: expected %0d, actual %0d", exp_ev.event_res, out_event_res);
            mismatch_count++;
          end
          if (out_data !== exp_ev.data) begin
            $error("data: expected %0h, actual %0h", exp_ev.data, out_data);
            mismatch_count++;
          end
          if (out_payload_last !== exp_ev.payload_last) begin
            $error("payload_last: expected %0d, actual %0d",
                   exp_ev.payload_last, out_payload_last);
            mismatch_count++;
          end
          if (out_payload_length !== exp_ev.payload_length) begin
            $error("payload_length: expected %0d, actual %0d",
                   exp_ev.payload_length, out_payload_length);
            mismatch_count++;
          end
          if (out_in_error !== exp_ev.in_error) begin
            $error("in_error: expected %0d, actual %0d", exp_ev.in_error, out_in_error);
            mismatch_count++;
          end
        end
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // Watchdog: end the run if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Sender: bursts of back-to-back transactions separated by random gaps.
  // Hold the payload while stalled; advance only once the last one was taken.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  link_item_t  driven_item;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled: hold everything
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (link_items.size() != 0) begin
      driven_item = link_items.pop_front();
      in_valid   <= 1'b1;
      in_opcode  <= driven_item.op;
      in_rx_byte <= driven_item.rx;
      if (burst_left <= 1) begin
        // mostly short bursts, now and then a long stretch with no idling
        burst_left <= ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: switch at random between stall patterns:
  // never, light random, heavy random, and a fixed duty cycle.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 256);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 9) < 3);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((stall_left % 6) < 4);
      endcase
    end
  end

  task automatic add_item(input logic [1:0] op, input logic [7:0] b);
    link_items.push_back('{op, b});
    queued_count++;
  endtask

  task automatic add_header(input logic [15:0] len);
    add_item(dfr_pkg::OP_BYTE, dfr_pkg::HDR1_BYTE);
    add_item(dfr_pkg::OP_BYTE, dfr_pkg::HDR2_BYTE);
    add_item(dfr_pkg::OP_BYTE, len[7:0]);
    add_item(dfr_pkg::OP_BYTE, len[15:8]);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Wait until every queued transaction went in and every event came out,
  // then let the pipeline settle so no late result is still on its way.
  task automatic wait_drained();
    while (link_items.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; the rest is broken frames,
  // raw noise and deliberate timeouts.
  task automatic queue_random_traffic(input int unsigned target);
    int unsigned first, kind, n;
    logic [15:0] len;
    logic [7:0]  b;
    logic [1:0]  op;
    bit          saw_err;
    first = queued_count;
    while (queued_count - first < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 68) begin
        // leading line noise that cannot start a header
        repeat ($urandom_range(0, 2)) begin
          b = 8'($urandom_range(0, 254));
          if (b >= dfr_pkg::HDR1_BYTE) b = b + 8'd1;
          add_item(dfr_pkg::OP_BYTE, b);
        end
        n = $urandom_range(0, 99);
        if (n < 3)       len = 16'd0;
        else if (n < 10) len = 16'd1;
        else if (n < 95) len = 16'($urandom_range(2, 14));
        else             len = 16'($urandom_range(64, 300));
        add_header(len);
        if (len != 16'd0) begin
          for (int i = 1; i < len; i++) begin
            if ($urandom_range(0, 19) == 0)
              add_item(dfr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
            add_item(dfr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
          end
          add_item(dfr_pkg::OP_BYTE, ($urandom_range(0, 99) < 85) ? dfr_pkg::FOOTER_BYTE
                                                                  : 8'($urandom_range(0, 255)));
        end
      end else if (kind < 78) begin
        case ($urandom_range(0, 2))
          0: begin
            // wrong second header byte
            b = 8'($urandom_range(0, 254));
            if (b >= dfr_pkg::HDR2_BYTE) b = b + 8'd1;
            add_item(dfr_pkg::OP_BYTE, dfr_pkg::HDR1_BYTE);
            add_item(dfr_pkg::OP_BYTE, b);
          end
          1: begin
            // any length, cut short by go-idle unless the frame ends first
            add_header(16'($urandom_range(0, 65535)));
            repeat ($urandom_range(0, 3))
              add_item(dfr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            add_item(dfr_pkg::OP_GO_IDLE, 8'($urandom_range(0, 255)));
          end
          default: begin
            // read error mid-frame, ignored traffic, then recover
            add_header(16'($urandom_range(1, 65535)));
            repeat ($urandom_range(0, 2))
              add_item(dfr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            add_item(dfr_pkg::OP_RD_ERR, 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3))
              add_item(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
            add_item(dfr_pkg::OP_GO_IDLE, 8'($urandom_range(0, 255)));
          end
        endcase
      end else if (kind < 88) begin
        // raw noise over all opcodes; recover from any read error
        saw_err = 1'b0;
        repeat ($urandom_range(1, 6)) begin
          op = 2'($urandom_range(0, 3));
          if (op == dfr_pkg::OP_RD_ERR) saw_err = 1'b1;
          add_item(op, 8'($urandom_range(0, 255)));
        end
        if (saw_err) add_item(dfr_pkg::OP_GO_IDLE, 8'($urandom_range(0, 255)));
      end else begin
        // start a frame and go quiet until timeout, or one tick short of it
        add_header(16'($urandom_range(1, 65535)));
        repeat ($urandom_range(0, 2))
          add_item(dfr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        repeat (cur_timeout - 1 + $urandom_range(0, 1))
          add_item(dfr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset state: disabled, so bytes, ticks and read errors are dropped.
    add_item(dfr_pkg::OP_BYTE, dfr_pkg::HDR1_BYTE);
    add_item(dfr_pkg::OP_TICK, 8'hFF);
    add_item(dfr_pkg::OP_RD_ERR, 8'h00);
    add_item(dfr_pkg::OP_GO_IDLE, 8'h00);
    wait_drained();

    cur_timeout = 16'd3;
    write_reg(dfr_pkg::CFG_ENABLE, 16'h0001);
    write_reg(dfr_pkg::CFG_TIMEOUT, cur_timeout);
    // length zero: rejected at once
    add_header(16'h0000);
    // length one: footer only, good frame with no payload
    add_header(16'h0001);
    add_item(dfr_pkg::OP_BYTE, dfr_pkg::FOOTER_BYTE);
    // two payload bytes at the byte extremes, then a wrong footer
    add_header(16'h0003);
    add_item(dfr_pkg::OP_BYTE, 8'hFF);
    add_item(dfr_pkg::OP_BYTE, 8'h00);
    add_item(dfr_pkg::OP_BYTE, 8'h55);
    // wrong second header byte, then a tick while hunting
    add_item(dfr_pkg::OP_BYTE, dfr_pkg::HDR1_BYTE);
    add_item(dfr_pkg::OP_BYTE, 8'h7F);
    add_item(dfr_pkg::OP_TICK, 8'h00);
    // quiet frame runs into the timeout
    add_header(16'h0002);
    repeat (3) add_item(dfr_pkg::OP_TICK, 8'h00);
    // read error, ignored traffic in the error state, go idle
    add_item(dfr_pkg::OP_RD_ERR, 8'h00);
    add_item(dfr_pkg::OP_BYTE, dfr_pkg::HDR1_BYTE);
    add_item(dfr_pkg::OP_GO_IDLE, 8'h00);
    wait_drained();

    // Shortest timeout: any tick inside a frame ends it.
    cur_timeout = 16'd1;
    write_reg(dfr_pkg::CFG_TIMEOUT, cur_timeout);
    queue_random_traffic(240);
    wait_drained();

    cur_timeout = 16'($urandom_range(2, 20));
    write_reg(dfr_pkg::CFG_TIMEOUT, cur_timeout);
    queue_random_traffic(430);
    wait_drained();

    // Disable while possibly mid-frame: takes effect only once idle again.
    write_reg(dfr_pkg::CFG_ENABLE, 16'h0000);
    queue_random_traffic(110);
    wait_drained();

    // Widest settings: largest length cut short, then a quiet frame at the
    // longest timeout that still completes.
    cur_timeout = 16'hFFFF;
    write_reg(dfr_pkg::CFG_ENABLE, 16'h0001);
    write_reg(dfr_pkg::CFG_TIMEOUT, cur_timeout);
    add_item(dfr_pkg::OP_GO_IDLE, 8'h00);
    add_header(16'hFFFF);
    repeat (6) add_item(dfr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
    add_item(dfr_pkg::OP_GO_IDLE, 8'h00);
    add_header(16'h0005);
    repeat (40) add_item(dfr_pkg::OP_TICK, 8'($urandom_range(0, 255)));
    repeat (4) add_item(dfr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
    add_item(dfr_pkg::OP_BYTE, dfr_pkg::FOOTER_BYTE);
    wait_drained();

    cur_timeout = 16'($urandom_range(21, 40));
    write_reg(dfr_pkg::CFG_TIMEOUT, cur_timeout);
    queue_random_traffic(520);
    wait_drained();

    if (expected_events.size() != 0) begin
      $error("%0d expected results never arrived", expected_events.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* length_framed_packet_deframer_top.f */
rtl/dfr_pkg.sv
rtl/dfr_core.sv
rtl/length_framed_packet_deframer_top.sv
bench/length_framed_packet_deframer_top_test.sv
